>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. Defining ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every rising edge, switched off while reset is asserted.
`define HRFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("heater relay supervisor assertion failed");
// Checked at every rising edge, reset included.
`define HRFS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("heater relay supervisor assertion failed");
`else
`define HRFS_ASSERT(lbl, clk, rst_n, prop)
`define HRFS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/hrfs_pkg.sv
package hrfs_pkg;

  // Supervisor status as reported on the result channel.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MON   = 3'd1,
    ST_PRE   = 3'd2,
    ST_FAULT = 3'd3,
    ST_RESET = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ORG_NONE      = 2'd0,
    ORG_GENERIC   = 2'd1,
    ORG_OFF_STUCK = 2'd2,
    ORG_ON_OPEN   = 2'd3
  } origin_e;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_PRE_ON      = 3'd0,
    REG_FAULT_ON    = 3'd1,
    REG_SCALE_ON    = 3'd2,
    REG_PRE_OFF     = 3'd3,
    REG_FAULT_OFF   = 3'd4,
    REG_SCALE_OFF   = 3'd5,
    REG_HOT_TIME    = 3'd6,
    REG_HOT_PRESENT = 3'd7
  } reg_idx_e;

  localparam int unsigned CFG_ADDR_W = 5;

  // Heater feedback codes.
  localparam logic [2:0] FB_ON_OK     = 3'd1;
  localparam logic [2:0] FB_OFF_OK    = 3'd2;
  localparam logic [2:0] FB_OFF_ERR   = 3'd3;
  localparam logic [2:0] FB_OFF_STUCK = 3'd4;
  localparam logic [2:0] FB_ON_ERR    = 3'd5;
  localparam logic [2:0] FB_ON_OPEN   = 3'd6;

  // Scale codes for the fault time bases.
  localparam logic [7:0] SCALE_X10  = 8'h10;
  localparam logic [7:0] SCALE_X100 = 8'h18;

  localparam logic [15:0] HOT_DEFAULT_TICKS = 16'd30;
  localparam logic [7:0]  HOT_TIME_RESET    = 8'd3;

  typedef struct packed {
    logic [15:0] pre_on;
    logic [7:0]  fault_on;
    logic [7:0]  scale_on;
    logic [15:0] pre_off;
    logic [7:0]  fault_off;
    logic [7:0]  scale_off;
    logic [7:0]  hot_time;
    logic        hot_present;
  } cfg_t;

  // Phase flags, on_init in the least significant bit.
  typedef struct packed {
    logic filt;
    logic off_rst;
    logic on_rst;
    logic off;
    logic off_init;
    logic on;
    logic on_init;
  } flags_t;

  // Fault time from a base and a scale code; zero under test timers.
  function automatic logic [15:0] fault_time(input logic [7:0] base,
                                             input logic [7:0] scale,
                                             input logic       test);
    logic [15:0] t;
    t = 16'd0;
    if (!test) begin
      if (scale == SCALE_X10) begin
        t = 16'(base) * 16'd10;
      end else if (scale == SCALE_X100) begin
        t = 16'(base) * 16'd100;
      end
    end
    return t;
  endfunction

endpackage

>>> sv/hrfs_if.sv
// Tick channel into the supervisor.
interface hrfs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] feedback_code;
  logic       zero_cross_good;
  logic       drive_requested;
  logic       heater_hot;
  logic       test_timers;
  logic       clear_fault;

  modport source (
    output valid, feedback_code, zero_cross_good, drive_requested,
           heater_hot, test_timers, clear_fault,
    input  ready
  );
  modport sink (
    input  valid, feedback_code, zero_cross_good, drive_requested,
           heater_hot, test_timers, clear_fault,
    output ready
  );
endinterface

// Status channel out of the supervisor.
interface hrfs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  supervisor_status;
  logic [1:0]  fault_origin;
  logic [15:0] ticks_left;

  modport source (
    output valid, supervisor_status, fault_origin, ticks_left,
    input  ready
  );
  modport sink (
    input  valid, supervisor_status, fault_origin, ticks_left,
    output ready
  );
endinterface

>>> sv/hrfs_cfg.sv
// Configuration registers behind the APB-style port.
module hrfs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrfs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output hrfs_pkg::cfg_t                   cfg_o
);

  hrfs_pkg::cfg_t   cfg_q, cfg_d;
  hrfs_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = hrfs_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        hrfs_pkg::REG_PRE_ON:      cfg_d.pre_on      = pwdata[15:0];
        hrfs_pkg::REG_FAULT_ON:    cfg_d.fault_on    = pwdata[7:0];
        hrfs_pkg::REG_SCALE_ON:    cfg_d.scale_on    = pwdata[7:0];
        hrfs_pkg::REG_PRE_OFF:     cfg_d.pre_off     = pwdata[15:0];
        hrfs_pkg::REG_FAULT_OFF:   cfg_d.fault_off   = pwdata[7:0];
        hrfs_pkg::REG_SCALE_OFF:   cfg_d.scale_off   = pwdata[7:0];
        hrfs_pkg::REG_HOT_TIME:    cfg_d.hot_time    = pwdata[7:0];
        hrfs_pkg::REG_HOT_PRESENT: cfg_d.hot_present = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hrfs_pkg::REG_PRE_ON:      prdata = {16'd0, cfg_q.pre_on};
      hrfs_pkg::REG_FAULT_ON:    prdata = {24'd0, cfg_q.fault_on};
      hrfs_pkg::REG_SCALE_ON:    prdata = {24'd0, cfg_q.scale_on};
      hrfs_pkg::REG_PRE_OFF:     prdata = {16'd0, cfg_q.pre_off};
      hrfs_pkg::REG_FAULT_OFF:   prdata = {24'd0, cfg_q.fault_off};
      hrfs_pkg::REG_SCALE_OFF:   prdata = {24'd0, cfg_q.scale_off};
      hrfs_pkg::REG_HOT_TIME:    prdata = {24'd0, cfg_q.hot_time};
      hrfs_pkg::REG_HOT_PRESENT: prdata = {31'd0, cfg_q.hot_present};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pre_on: 16'd0, fault_on: 8'd0, scale_on: 8'd0, pre_off: 16'd0,
                 fault_off: 8'd0, scale_off: 8'd0, hot_time: hrfs_pkg::HOT_TIME_RESET,
                 hot_present: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/heater_relay_fault_supervisor.sv
// Channel   Direction  Carries
// in_i      sink       one 10 ms tick: feedback code, zero-cross flag, drive, hot,
//                      test timers, clear fault
// out_o     source     supervisor status, fault origin, ticks left
// APB       slave      eight configuration registers at byte addresses 0 to 28
//
// One item can be accepted in every clock cycle while out_o takes its results; each
// is stepped from the input register into the result register and offered from there.
// The whole supervisor step is one pass of logic from the input register into the
// state and result registers, so the state loop closes through the state registers alone.
// Reset is asynchronous and active low; it clears the handshake and the supervisor state.
// When out_o is stalled the result register holds, the input register still takes
// one more item, and in_i.ready then falls until the result is taken.
`include "assert_macros.svh"

module heater_relay_fault_supervisor #(
  parameter int unsigned FILTER_TICKS = 50
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hrfs_in_if.sink                          in_i,
  hrfs_out_if.source                       out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrfs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // The prefault reset filter only ever counts down from FILTER_TICKS.
  localparam int unsigned FW = $clog2(FILTER_TICKS + 1);
  localparam logic [FW-1:0] FILT_LOAD = FW'(FILTER_TICKS);
  localparam logic [15:0]   FILT_16   = 16'(FILTER_TICKS);

  hrfs_pkg::cfg_t cfg;

  hrfs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Handshake: an input register followed by a result register. The step runs
  // when the input register holds an item and the result register is free or is
  // being emptied in the same cycle.
  // ---------------------------------------------------------------------------
  logic       s1_valid_q;
  logic [2:0] s1_code_q;
  logic       s1_zc_q, s1_drive_q, s1_hot_q, s1_test_q, s1_clr_q;
  logic       out_valid_q;
  logic       adv;

  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_code_q  <= in_i.feedback_code;
      s1_zc_q    <= in_i.zero_cross_good;
      s1_drive_q <= in_i.drive_requested;
      s1_hot_q   <= in_i.heater_hot;
      s1_test_q  <= in_i.test_timers;
      s1_clr_q   <= in_i.clear_fault;
    end
  end

  // ---------------------------------------------------------------------------
  // Supervisor state.
  // ---------------------------------------------------------------------------
  hrfs_pkg::status_e status_q, status_d;
  hrfs_pkg::origin_e origin_q, origin_d;
  logic [15:0]       ft_q, ft_d;
  logic [FW-1:0]     flt_q, flt_d;
  hrfs_pkg::flags_t  flags_q, flags_d;

  // Timings for this tick, with test timers applied.
  logic [15:0] pre_on_t, pre_off_t, fault_on_t, fault_off_t, hot_t;

  assign pre_on_t  = (s1_test_q && cfg.pre_on  > FILT_16) ? FILT_16 : cfg.pre_on;
  assign pre_off_t = (s1_test_q && cfg.pre_off > FILT_16) ? FILT_16 : cfg.pre_off;
  assign fault_on_t  = hrfs_pkg::fault_time(cfg.fault_on,  cfg.scale_on,  s1_test_q);
  assign fault_off_t = hrfs_pkg::fault_time(cfg.fault_off, cfg.scale_off, s1_test_q);
  assign hot_t = s1_test_q ? 16'd0 :
                 (cfg.hot_present ? 16'(cfg.hot_time) * 16'd10
                                  : hrfs_pkg::HOT_DEFAULT_TICKS);

  logic [2:0] code;
  logic       ev_reset, ev_off_mon, ev_on_mon, ev_on_init, ev_off_init;
  logic       begin_off, begin_on;

  always_comb begin
    // Both timers count down once per tick before anything else happens.
    ft_d     = ft_q - {15'd0, (ft_q != 16'd0)};
    flt_d    = flt_q - FW'(flt_q != '0);
    flags_d  = flags_q;
    status_d = status_q;
    origin_d = origin_q;
    code       = 3'd0;
    ev_reset   = 1'b0;
    ev_off_mon = 1'b0;
    ev_on_mon  = 1'b0;
    begin_off  = 1'b0;
    begin_on   = 1'b0;

    // Feedback classification; skipped entirely while in fault. Without a good
    // zero crossing the feedback is taken to agree with the drive request.
    if (status_q != hrfs_pkg::ST_FAULT) begin
      code = s1_zc_q ? s1_code_q
                     : (s1_drive_q ? hrfs_pkg::FB_ON_OK : hrfs_pkg::FB_OFF_OK);
      case (code) inside
        hrfs_pkg::FB_ON_OK, hrfs_pkg::FB_ON_ERR, hrfs_pkg::FB_ON_OPEN: begin
          flags_d.on_init  = !flags_d.on;
          flags_d.on       = 1'b1;
          flags_d.off      = 1'b0;
          flags_d.off_init = 1'b0;
        end
        hrfs_pkg::FB_OFF_OK, hrfs_pkg::FB_OFF_ERR, hrfs_pkg::FB_OFF_STUCK: begin
          flags_d.off_init = !flags_d.off;
          flags_d.off      = 1'b1;
          flags_d.on       = 1'b0;
          flags_d.on_init  = 1'b0;
        end
        default: ;
      endcase
      case (code) inside
        hrfs_pkg::FB_ON_OK:  flags_d.on_rst  = 1'b1;
        hrfs_pkg::FB_OFF_OK: flags_d.off_rst = 1'b1;
        hrfs_pkg::FB_OFF_ERR, hrfs_pkg::FB_OFF_STUCK,
        hrfs_pkg::FB_ON_ERR,  hrfs_pkg::FB_ON_OPEN: begin
          // Any error cancels a pending reset and its filter.
          flags_d.on_rst  = 1'b0;
          flags_d.off_rst = 1'b0;
          flags_d.filt    = 1'b0;
          flt_d           = '0;
          ev_off_mon = (code == hrfs_pkg::FB_OFF_ERR) || (code == hrfs_pkg::FB_OFF_STUCK);
          ev_on_mon  = (code == hrfs_pkg::FB_ON_ERR)  || (code == hrfs_pkg::FB_ON_OPEN);
        end
        default: ;
      endcase
    end

    ev_on_init  = flags_d.on_init;
    ev_off_init = flags_d.off_init;

    // Good feedback resets monitoring at once; in prefault it must first pass
    // the filter, and the filter starts only with enough fault time left.
    if (flags_d.on_rst || flags_d.off_rst) begin
      if (status_q == hrfs_pkg::ST_MON) begin
        ev_reset = 1'b1;
      end else if (status_q == hrfs_pkg::ST_PRE) begin
        if (ft_d > FILT_16 && !flags_d.filt) begin
          flt_d        = FILT_LOAD;
          flags_d.filt = 1'b1;
        end
        if (flt_d == '0 && flags_d.filt) begin
          ev_reset     = 1'b1;
          flags_d.filt = 1'b0;
        end
      end
    end

    case (status_q)
      hrfs_pkg::ST_IDLE: begin
        if (ev_off_mon) begin
          status_d  = hrfs_pkg::ST_MON;
          begin_off = 1'b1;
        end else if (ev_on_mon) begin
          status_d = hrfs_pkg::ST_MON;
          begin_on = 1'b1;
        end
      end
      hrfs_pkg::ST_RESET: begin
        if (ft_d == 16'd0) begin
          origin_d = hrfs_pkg::ORG_NONE;
          status_d = hrfs_pkg::ST_IDLE;
        end
      end
      hrfs_pkg::ST_MON: begin
        if (ev_reset) begin
          status_d = hrfs_pkg::ST_RESET;
          ft_d     = 16'd0;
        end else if (ft_d == 16'd0) begin
          status_d = hrfs_pkg::ST_PRE;
          if (ev_off_mon) begin
            ft_d = fault_off_t;
          end else if (ev_on_mon) begin
            ft_d = (origin_q == hrfs_pkg::ORG_ON_OPEN && s1_hot_q) ? hot_t : fault_on_t;
          end
        end else if (ev_off_init && ev_off_mon) begin
          begin_off = 1'b1;
        end else if (ev_on_init && ev_on_mon) begin
          begin_on = 1'b1;
        end
      end
      hrfs_pkg::ST_PRE: begin
        if (ev_reset) begin
          status_d = hrfs_pkg::ST_RESET;
          ft_d     = 16'd0;
        end else if (ev_off_init && ev_off_mon) begin
          status_d  = hrfs_pkg::ST_MON;
          begin_off = 1'b1;
        end else if (ev_on_init && ev_on_mon) begin
          status_d = hrfs_pkg::ST_MON;
          begin_on = 1'b1;
        end else if (ft_d == 16'd0) begin
          status_d = hrfs_pkg::ST_FAULT;
        end
      end
      hrfs_pkg::ST_FAULT: begin
        if (s1_clr_q) begin
          status_d = hrfs_pkg::ST_RESET;
        end
      end
      default: ;
    endcase

    // Start of a monitoring period: load the prefault time and record the source.
    if (begin_off) begin
      ft_d     = pre_off_t;
      origin_d = (code == hrfs_pkg::FB_OFF_ERR) ? hrfs_pkg::ORG_GENERIC
                                                : hrfs_pkg::ORG_OFF_STUCK;
    end else if (begin_on) begin
      ft_d     = pre_on_t;
      origin_d = (code == hrfs_pkg::FB_ON_ERR) ? hrfs_pkg::ORG_GENERIC
                                               : hrfs_pkg::ORG_ON_OPEN;
      // From idle, a hot heater with a stuck-open relay goes straight to the fault time.
      if (status_q == hrfs_pkg::ST_IDLE && code != hrfs_pkg::FB_ON_ERR && s1_hot_q) begin
        ft_d = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= hrfs_pkg::ST_IDLE;
      origin_q <= hrfs_pkg::ORG_NONE;
      ft_q     <= 16'd0;
      flt_q    <= '0;
      flags_q  <= '0;
    end else if (adv) begin
      status_q <= status_d;
      origin_q <= origin_d;
      ft_q     <= ft_d;
      flt_q    <= flt_d;
      flags_q  <= flags_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [2:0]  res_status_q;
  logic [1:0]  res_origin_q;
  logic [15:0] res_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_status_q <= status_d;
      res_origin_q <= origin_d;
      res_ticks_q  <= ft_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.supervisor_status = res_status_q;
  assign out_o.fault_origin      = res_origin_q;
  assign out_o.ticks_left        = res_ticks_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // In fault the feedback is ignored: without a clear request nothing moves.
  `HRFS_ASSERT(a_fault_holds, clk_i, rst_ni,
    (adv && status_q == hrfs_pkg::ST_FAULT && !s1_clr_q) |=>
      (status_q == hrfs_pkg::ST_FAULT && $stable(flags_q)))
  // Fault is only entered from prefault.
  `HRFS_ASSERT(a_fault_from_pre, clk_i, rst_ni,
    (adv && status_q != hrfs_pkg::ST_PRE && status_q != hrfs_pkg::ST_FAULT) |=>
      (status_q != hrfs_pkg::ST_FAULT))
  // Idle never carries a fault source.
  `HRFS_ASSERT(a_idle_no_origin, clk_i, rst_ni,
    (status_q == hrfs_pkg::ST_IDLE) |-> (origin_q == hrfs_pkg::ORG_NONE))
  // The reset filter only runs while its flag is set.
  `HRFS_ASSERT(a_filter_flag, clk_i, rst_ni,
    (flt_q != '0) |-> flags_q.filt)

endmodule

>>> tb/heater_relay_fault_supervisor_tb.sv
`timescale 1ns / 100ps

module heater_relay_fault_supervisor_tb;

  // The prefault reset filter length, as the block is built with its default.
  localparam int unsigned PREFAULT_FILTER = 50;
  // Cycles in which nothing at all is accepted before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;

  // Event bits raised while a tick is classified.
  localparam logic [4:0] EV_RESET    = 5'h01;
  localparam logic [4:0] EV_OFF_MON  = 5'h02;
  localparam logic [4:0] EV_ON_MON   = 5'h04;
  localparam logic [4:0] EV_ON_INIT  = 5'h08;
  localparam logic [4:0] EV_OFF_INIT = 5'h10;

  // One 10 ms tick as it travels on the input channel.
  typedef struct packed {
    logic [2:0] code;
    logic       zc;
    logic       drive;
    logic       hot;
    logic       test;
    logic       clr;
  } tick_t;

  // One status report as it travels on the result channel.
  typedef struct packed {
    hrfs_pkg::status_e status;
    hrfs_pkg::origin_e origin;
    logic [15:0]       left;
  } status_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [hrfs_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hrfs_in_if  in_if ();
  hrfs_out_if out_if ();

  heater_relay_fault_supervisor uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ticks waiting to be sent, and the status reports they are due to produce.
  tick_t        tick_queue[$];
  status_word_t expected_status[$];
  int           ticks_queued = 0;
  int           error_count = 0;

  // ---------------------------------------------------------------------------
  // Supervisor prediction. This is a private copy of the configuration and of
  // the supervisor state, advanced once for every tick the block accepts.
  // ---------------------------------------------------------------------------
  hrfs_pkg::cfg_t    cfg_m;
  hrfs_pkg::status_e sup_state = hrfs_pkg::ST_IDLE;
  hrfs_pkg::origin_e sup_origin = hrfs_pkg::ORG_NONE;
  logic [15:0]       fault_cnt = '0;
  logic [7:0]        filter_cnt = '0;
  hrfs_pkg::flags_t  phase = '0;

  // Under test timers the prefault time is clamped to the filter length.
  function automatic logic [15:0] prefault_span(input logic [15:0] ticks, input logic test);
    if (test && ticks > PREFAULT_FILTER) return 16'(PREFAULT_FILTER);
    return ticks;
  endfunction

  // The fault time is the base times ten or a hundred; other scales or test timers give none.
  function automatic logic [15:0] fault_span(input logic [7:0] base, input logic [7:0] scale,
                                             input logic test);
    if (test) return 16'd0;
    case (scale)
      hrfs_pkg::SCALE_X10:  return {8'd0, base} * 16'd10;
      hrfs_pkg::SCALE_X100: return {8'd0, base} * 16'd100;
      default:              return 16'd0;
    endcase
  endfunction

  // Fault time for a relay that stays open while the water is hot.
  function automatic logic [15:0] hot_span(input logic test);
    if (test) return 16'd0;
    if (cfg_m.hot_present) return {8'd0, cfg_m.hot_time} * 16'd10;
    return hrfs_pkg::HOT_DEFAULT_TICKS;
  endfunction

  // The init flag of a phase is set on its first tick and cleared on the next one.
  function automatic void mark_on_phase();
    phase.on_init = !phase.on;
    phase.on = 1'b1;
    phase.off = 1'b0;
    phase.off_init = 1'b0;
  endfunction

  function automatic void mark_off_phase();
    phase.off_init = !phase.off;
    phase.off = 1'b1;
    phase.on = 1'b0;
    phase.on_init = 1'b0;
  endfunction

  function automatic void start_off_watch(input logic [2:0] code, input logic test);
    fault_cnt = prefault_span(cfg_m.pre_off, test);
    if (code == hrfs_pkg::FB_OFF_ERR) sup_origin = hrfs_pkg::ORG_GENERIC;
    else sup_origin = hrfs_pkg::ORG_OFF_STUCK;
  endfunction

  function automatic void start_on_watch(input logic [2:0] code, input logic test);
    fault_cnt = prefault_span(cfg_m.pre_on, test);
    if (code == hrfs_pkg::FB_ON_ERR) sup_origin = hrfs_pkg::ORG_GENERIC;
    else sup_origin = hrfs_pkg::ORG_ON_OPEN;
  endfunction

  // Advances the supervisor by one tick and returns the status it reports.
  function automatic status_word_t step_supervisor(input tick_t t);
    logic [2:0]   code;
    logic [4:0]   ev;
    status_word_t r;
    code = 3'd0;
    ev = '0;
    if (fault_cnt != 0) fault_cnt = fault_cnt - 16'd1;
    if (filter_cnt != 0) filter_cnt = filter_cnt - 8'd1;

    // In fault the feedback is not looked at at all.
    if (sup_state != hrfs_pkg::ST_FAULT) begin
      if (t.zc) code = t.code;
      else if (t.drive) code = hrfs_pkg::FB_ON_OK;
      else code = hrfs_pkg::FB_OFF_OK;
      case (code)
        hrfs_pkg::FB_ON_OK: begin
          mark_on_phase();
          phase.on_rst = 1'b1;
        end
        hrfs_pkg::FB_OFF_OK: begin
          mark_off_phase();
          phase.off_rst = 1'b1;
        end
        hrfs_pkg::FB_OFF_ERR, hrfs_pkg::FB_OFF_STUCK: begin
          mark_off_phase();
          phase.on_rst = 1'b0;
          phase.off_rst = 1'b0;
          phase.filt = 1'b0;
          filter_cnt = '0;
          ev |= EV_OFF_MON;
        end
        hrfs_pkg::FB_ON_ERR, hrfs_pkg::FB_ON_OPEN: begin
          mark_on_phase();
          phase.on_rst = 1'b0;
          phase.off_rst = 1'b0;
          phase.filt = 1'b0;
          filter_cnt = '0;
          ev |= EV_ON_MON;
        end
        default: ;
      endcase
    end

    if (phase.on_init) ev |= EV_ON_INIT;
    if (phase.off_init) ev |= EV_OFF_INIT;
    // Good feedback resets monitoring at once, but prefault only through the filter.
    if (phase.on_rst || phase.off_rst) begin
      if (sup_state == hrfs_pkg::ST_MON) begin
        ev |= EV_RESET;
      end else if (sup_state == hrfs_pkg::ST_PRE) begin
        if (fault_cnt > PREFAULT_FILTER && !phase.filt) begin
          filter_cnt = 8'(PREFAULT_FILTER);
          phase.filt = 1'b1;
        end
        if (filter_cnt == 0 && phase.filt) begin
          ev |= EV_RESET;
          phase.filt = 1'b0;
        end
      end
    end

    case (sup_state)
      hrfs_pkg::ST_IDLE: begin
        if (ev & EV_OFF_MON) begin
          sup_state = hrfs_pkg::ST_MON;
          start_off_watch(code, t.test);
        end else if (ev & EV_ON_MON) begin
          sup_state = hrfs_pkg::ST_MON;
          start_on_watch(code, t.test);
          if (code != hrfs_pkg::FB_ON_ERR && t.hot) fault_cnt = '0;
        end
      end
      hrfs_pkg::ST_RESET: begin
        if (fault_cnt == 0) begin
          sup_origin = hrfs_pkg::ORG_NONE;
          sup_state = hrfs_pkg::ST_IDLE;
        end
      end
      hrfs_pkg::ST_MON: begin
        if (ev & EV_RESET) begin
          sup_state = hrfs_pkg::ST_RESET;
          fault_cnt = '0;
        end else if (fault_cnt == 0) begin
          sup_state = hrfs_pkg::ST_PRE;
          if (ev & EV_OFF_MON) begin
            fault_cnt = fault_span(cfg_m.fault_off, cfg_m.scale_off, t.test);
          end else if (ev & EV_ON_MON) begin
            if (sup_origin == hrfs_pkg::ORG_ON_OPEN && t.hot) fault_cnt = hot_span(t.test);
            else fault_cnt = fault_span(cfg_m.fault_on, cfg_m.scale_on, t.test);
          end
        end else if ((ev & (EV_OFF_INIT | EV_OFF_MON)) == (EV_OFF_INIT | EV_OFF_MON)) begin
          start_off_watch(code, t.test);
        end else if ((ev & (EV_ON_INIT | EV_ON_MON)) == (EV_ON_INIT | EV_ON_MON)) begin
          start_on_watch(code, t.test);
        end
      end
      hrfs_pkg::ST_PRE: begin
        if (ev & EV_RESET) begin
          sup_state = hrfs_pkg::ST_RESET;
          fault_cnt = '0;
        end else if ((ev & (EV_OFF_INIT | EV_OFF_MON)) == (EV_OFF_INIT | EV_OFF_MON)) begin
          sup_state = hrfs_pkg::ST_MON;
          start_off_watch(code, t.test);
        end else if ((ev & (EV_ON_INIT | EV_ON_MON)) == (EV_ON_INIT | EV_ON_MON)) begin
          sup_state = hrfs_pkg::ST_MON;
          start_on_watch(code, t.test);
        end else if (fault_cnt == 0) begin
          sup_state = hrfs_pkg::ST_FAULT;
        end
      end
      hrfs_pkg::ST_FAULT: begin
        if (t.clr) sup_state = hrfs_pkg::ST_RESET;
      end
      default: ;
    endcase

    r.status = sup_state;
    r.origin = sup_origin;
    r.left = fault_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver. It sends in bursts of random length with random gaps, and the
  // prediction is advanced at the very edge at which a tick is accepted.
  // ---------------------------------------------------------------------------
  tick_t cur_tick;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_status.push_back(step_supervisor(cur_tick));
      end
      // A tick that was offered but not taken stays on the channel unchanged.
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          cur_tick = tick_queue.pop_front();
          in_if.feedback_code   <= cur_tick.code;
          in_if.zero_cross_good <= cur_tick.zc;
          in_if.drive_requested <= cur_tick.drive;
          in_if.heater_hot      <= cur_tick.hot;
          in_if.test_timers     <= cur_tick.test;
          in_if.clear_fault     <= cur_tick.clr;
          in_if.valid           <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Roughly a third of the bursts are followed by no gap at all.
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Status monitor. The receiver stalls on a rotating random pattern that is
  // renewed now and then; some stretches take every report without a stall.
  // ---------------------------------------------------------------------------
  logic [15:0]  stall_pattern = 16'h0001;
  int           pattern_left = 0;
  logic         free_run = 1'b1;
  status_word_t due;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_status.size() == 0) begin
          $error("status report with no tick to account for it: status %0d origin %0d left %0d",
                 out_if.supervisor_status, out_if.fault_origin, out_if.ticks_left);
          error_count++;
        end else begin
          due = expected_status.pop_front();
          if (out_if.supervisor_status !== due.status) begin
            $error("supervisor_status: expected %0d, actual %0d",
                   due.status, out_if.supervisor_status);
            error_count++;
          end
          if (out_if.fault_origin !== due.origin) begin
            $error("fault_origin: expected %0d, actual %0d", due.origin, out_if.fault_origin);
            error_count++;
          end
          if (out_if.ticks_left !== due.left) begin
            $error("ticks_left: expected %0d, actual %0d", due.left, out_if.ticks_left);
            error_count++;
          end
        end
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(10, 80);
        free_run = ($urandom_range(0, 2) == 0);
        stall_pattern = 16'($urandom) | 16'h0001;
      end else begin
        pattern_left--;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_if.ready <= free_run | stall_pattern[0];
    end
  end

  // The watchdog restarts whenever anything moves on any of the three ports.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void push_tick(input logic [2:0] code, input logic zc, input logic drive,
                                    input logic hot, input logic test, input logic clr);
    tick_queue.push_back('{code: code, zc: zc, drive: drive, hot: hot, test: test, clr: clr});
    ticks_queued++;
  endfunction

  function automatic void push_noise_tick();
    push_tick(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom));
  endfunction

  // Waits until every tick has been sent and every report has come back.
  task automatic settle();
    while (tick_queue.size() != 0 || in_if.valid === 1'b1 || expected_status.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // One APB write: a setup cycle, then an access cycle that completes at once.
  task automatic write_register(input hrfs_pkg::reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes all eight registers. The bits above each register's width are
  // filled with noise, which the block must drop.
  task automatic set_config(input hrfs_pkg::cfg_t c);
    write_register(hrfs_pkg::REG_PRE_ON,      {16'($urandom), c.pre_on});
    write_register(hrfs_pkg::REG_FAULT_ON,    {24'($urandom), c.fault_on});
    write_register(hrfs_pkg::REG_SCALE_ON,    {24'($urandom), c.scale_on});
    write_register(hrfs_pkg::REG_PRE_OFF,     {16'($urandom), c.pre_off});
    write_register(hrfs_pkg::REG_FAULT_OFF,   {24'($urandom), c.fault_off});
    write_register(hrfs_pkg::REG_SCALE_OFF,   {24'($urandom), c.scale_off});
    write_register(hrfs_pkg::REG_HOT_TIME,    {24'($urandom), c.hot_time});
    write_register(hrfs_pkg::REG_HOT_PRESENT, {31'($urandom), c.hot_present});
    cfg_m = c;
    repeat (2) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_scale();
    case ($urandom_range(0, 3))
      0:       return hrfs_pkg::SCALE_X10;
      1:       return hrfs_pkg::SCALE_X100;
      2:       return 8'($urandom);
      default: return hrfs_pkg::SCALE_X10;
    endcase
  endfunction

  // Queues random fault scenarios. Most are a run of bad feedback, mostly of one kind,
  // long enough now and then to go all the way to fault, followed by a run of
  // good feedback that may or may not outlast the prefault filter. The rest are
  // short good stretches and pure noise. The last scenario is cut short so that
  // exactly n_ticks ticks are queued.
  task automatic queue_phase(input int n_ticks, input int test_pct);
    int         first;
    int         run_len;
    logic [2:0] bad_code;
    logic       hot;
    logic       test;
    logic       clr_on;
    logic       drive;
    logic       zc;
    @(negedge clk_i);
    first = ticks_queued;
    while (ticks_queued - first < n_ticks) begin
      test = ($urandom_range(0, 99) < test_pct);
      hot = 1'($urandom);
      clr_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 8)) push_noise_tick();
        end
        1, 2, 3, 4, 5, 6: begin
          bad_code = 3'($urandom_range(hrfs_pkg::FB_OFF_ERR, hrfs_pkg::FB_ON_OPEN));
          run_len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 15) : $urandom_range(20, 130);
          repeat (run_len) begin
            if ($urandom_range(0, 9) == 0) begin
              push_noise_tick();
            end else begin
              if ($urandom_range(0, 7) == 0) begin
                bad_code = 3'($urandom_range(hrfs_pkg::FB_OFF_ERR, hrfs_pkg::FB_ON_OPEN));
              end
              push_tick(bad_code, 1'b1, 1'($urandom), hot, test,
                        clr_on && ($urandom_range(0, 7) == 0));
            end
          end
          repeat ($urandom_range(0, 70)) begin
            drive = 1'($urandom);
            zc = 1'($urandom);
            // Without a valid zero crossing the code field is ignored, so it is left random.
            push_tick(zc ? (drive ? hrfs_pkg::FB_ON_OK : hrfs_pkg::FB_OFF_OK) : 3'($urandom),
                      zc, drive, hot, test, clr_on && ($urandom_range(0, 9) == 0));
          end
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            drive = 1'($urandom);
            push_tick(drive ? hrfs_pkg::FB_ON_OK : hrfs_pkg::FB_OFF_OK, 1'b1, drive, hot, test,
                      1'b0);
          end
        end
      endcase
    end
    // All of the above runs in one time step, so nothing has been sent yet.
    while (ticks_queued - first > n_ticks) begin
      void'(tick_queue.pop_back());
      ticks_queued--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  hrfs_pkg::cfg_t phase_cfg;

  initial begin
    // Every input is known before the first edge.
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.feedback_code = '0;
    in_if.zero_cross_good = 1'b0;
    in_if.drive_requested = 1'b0;
    in_if.heater_hot = 1'b0;
    in_if.test_timers = 1'b0;
    in_if.clear_fault = 1'b0;
    out_if.ready = 1'b0;
    cfg_m = '0;
    cfg_m.hot_time = hrfs_pkg::HOT_TIME_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks under the reset configuration, where every timing is zero
    // and the hot stuck-relay time falls back to its default of 30 ticks.
    push_tick(3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);           // off derived from the drive request
    push_tick(3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);           // on derived from the drive request
    push_tick(3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);           // invalid feedback
    push_tick(3'd7, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);           // the unused code is invalid too
    // Straight into fault.
    repeat (3) push_tick(hrfs_pkg::FB_OFF_ERR, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    // Good feedback has no effect in fault.
    push_tick(hrfs_pkg::FB_ON_OK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    push_tick(hrfs_pkg::FB_ON_OK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);   // clearing the fault
    push_tick(hrfs_pkg::FB_OFF_OK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    // Generic on error, hot.
    repeat (3) push_tick(hrfs_pkg::FB_ON_ERR, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    push_tick(hrfs_pkg::FB_OFF_OK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    push_tick(hrfs_pkg::FB_ON_OK, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    // An open relay while hot skips the prefault time and takes the hot fault time.
    push_tick(hrfs_pkg::FB_ON_OPEN, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    push_tick(hrfs_pkg::FB_ON_OPEN, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    push_tick(hrfs_pkg::FB_ON_OPEN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    // A change to an off error in prefault goes back to monitoring.
    push_tick(hrfs_pkg::FB_OFF_STUCK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(hrfs_pkg::FB_OFF_STUCK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    // Good feedback ends monitoring at once.
    push_tick(hrfs_pkg::FB_OFF_OK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(hrfs_pkg::FB_OFF_OK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    push_tick(hrfs_pkg::FB_ON_OPEN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    push_tick(hrfs_pkg::FB_ON_OPEN, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    settle();

    // Short prefault times and fault times above the filter length, so that
    // the filtered prefault reset is reached. The sender is made to wait for
    // every report halfway through.
    phase_cfg = '{pre_on: 16'd4, fault_on: 8'd8, scale_on: hrfs_pkg::SCALE_X10, pre_off: 16'd6,
                  fault_off: 8'd1, scale_off: hrfs_pkg::SCALE_X100, hot_time: 8'd7,
                  hot_present: 1'b1};
    set_config(phase_cfg);
    queue_phase(150, 20);
    settle();
    queue_phase(150, 20);
    settle();

    // No prefault time, and scale codes that give no fault time at all.
    phase_cfg = '{pre_on: 16'd0, fault_on: 8'd255, scale_on: 8'hFF, pre_off: 16'd0,
                  fault_off: 8'd0, scale_off: 8'h00, hot_time: 8'd255, hot_present: 1'b0};
    set_config(phase_cfg);
    queue_phase(200, 20);
    settle();

    // Every time register at its top value and both scales at times a hundred; test timers are needed to get anywhere.
    phase_cfg = '{pre_on: 16'hFFFF, fault_on: 8'd255, scale_on: hrfs_pkg::SCALE_X100,
                  pre_off: 16'hFFFF, fault_off: 8'd255, scale_off: hrfs_pkg::SCALE_X100,
                  hot_time: 8'd255, hot_present: 1'b1};
    set_config(phase_cfg);
    queue_phase(200, 90);
    settle();

    // Two random settings, kept small so that the timers run out.
    repeat (2) begin
      phase_cfg.pre_on = 16'($urandom_range(0, 20));
      phase_cfg.fault_on = 8'($urandom_range(0, 12));
      phase_cfg.scale_on = pick_scale();
      phase_cfg.pre_off = 16'($urandom_range(0, 20));
      phase_cfg.fault_off = 8'($urandom_range(0, 12));
      phase_cfg.scale_off = pick_scale();
      phase_cfg.hot_time = 8'($urandom_range(0, 12));
      phase_cfg.hot_present = 1'($urandom);
      set_config(phase_cfg);
      queue_phase(190, 25);
      settle();
    end

    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
